FILE: rtl/rv32i_instruction_executor_macros.svh
// ----------------------------------------------------------------------------
// RV32I executor assertion macros
// Shared property shapes for the checker that watches the top-level ports.
// ----------------------------------------------------------------------------
`ifndef RV32I_INSTRUCTION_EXECUTOR_MACROS_SVH
`define RV32I_INSTRUCTION_EXECUTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RVX_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rvx port check failed");

// The consequent must hold in the cycle after the antecedent.
`define RVX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rvx port check failed");

`endif

FILE: rtl/rvx_pkg.sv
// ----------------------------------------------------------------------------
// RV32I executor package
// Operation codes, result kinds, opcodes and the ALU control type.
// ----------------------------------------------------------------------------
package rvx_pkg;

    localparam logic [1:0] OPER_EXEC  = 2'd0;
    localparam logic [1:0] OPER_WRITE = 2'd1;
    localparam logic [1:0] OPER_READ  = 2'd2;
    localparam logic [1:0] OPER_NOP   = 2'd3;

    localparam logic [2:0] KIND_RETIRED = 3'd0;
    localparam logic [2:0] KIND_HALTED  = 3'd1;
    localparam logic [2:0] KIND_ILLEGAL = 3'd2;
    localparam logic [2:0] KIND_IDLE    = 3'd3;
    localparam logic [2:0] KIND_WRITTEN = 3'd4;
    localparam logic [2:0] KIND_REGREAD = 3'd5;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;
    localparam logic [31:0] LIMIT_RESET = 32'd1000000;

    typedef struct packed {
        logic [2:0] f3;
        logic       alt;
    } alu_ctl_t;

endpackage

FILE: rtl/rv32i_instruction_executor.sv
// ----------------------------------------------------------------------------
// RV32I instruction executor
// Multicycle RV32I core. An execute item passes from IDLE, where the fetch is
// issued, through FETCH and EXEC and, for loads and stores, MEM, since fetch
// and data share the one memory read port. Register reads pass through RREAD;
// program writes and idle answers come from IDLE. While one item is in progress
// the next can be accepted. After reset a clearing pass runs before any item.
// ----------------------------------------------------------------------------
module rv32i_instruction_executor
    import rvx_pkg::*;
#(
    parameter int unsigned MEMORY_WORDS = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [15:0] word_address,
    input  logic [31:0] word_data,
    input  logic [4:0]  reg_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  result_kind,
    output logic [31:0] insn_pc,
    output logic [31:0] insn_word,
    output logic [4:0]  dest_reg,
    output logic [31:0] dest_value,
    output logic        now_halted,
    output logic [31:0] retired_count
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RREAD = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_EXEC  = 5'b01000,
        ST_MEM   = 5'b10000
    } state_t;

    state_t      st_reg, st_next;
    logic [31:0] limit_reg;
    logic [31:0] pc_reg, pc_next;
    logic        halt_reg, halt_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] ir_reg, ir_next;
    logic [4:0]  ridx_reg, ridx_next;

    logic        in_full_reg;
    logic [1:0]  buf_op_reg;
    logic [15:0] buf_addr_reg;
    logic [31:0] buf_data_reg;
    logic [4:0]  buf_ridx_reg;
    logic        take_in;
    logic        consume;

    logic        out_valid_reg;
    logic [2:0]  kind_reg;
    logic [31:0] opc_pc_reg;
    logic [31:0] word_reg;
    logic [4:0]  rd_reg;
    logic [31:0] val_reg;
    logic        halted_reg;
    logic [31:0] count_reg;
    logic        out_free;
    logic        emit;
    logic        commit;
    logic [2:0]  res_kind;
    logic [31:0] res_pc;
    logic [31:0] res_word;
    logic [4:0]  res_rd;
    logic [31:0] res_val;

    logic        mem_busy;
    logic        mem_re;
    logic [29:0] mem_raddr;
    logic [31:0] mem_rdata;
    logic        mem_we;
    logic [29:0] mem_waddr;
    logic [31:0] mem_wdata;

    logic        rf_ra_en;
    logic [4:0]  rf_ra_idx;
    logic        rf_rb_en;
    logic [31:0] rf_a;
    logic [31:0] rf_b;
    logic        rf_we;

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
    logic [31:0] ea;
    logic [31:0] alu_b;
    alu_ctl_t    alu_ctl;
    logic [31:0] alu_res;
    logic        br_take;
    logic        illegal;
    logic        writes;
    logic        is_mem;
    logic [4:0]  byte_sh;
    logic [4:0]  half_sh;
    logic [4:0]  st_sh;
    logic [7:0]  bsel;
    logic [15:0] hsel;
    logic [31:0] load_val;
    logic [31:0] st_mask;
    logic [31:0] merged;
    logic [31:0] wr_val;
    logic [4:0]  rd_eff;
    logic [31:0] val_eff;
    logic [31:0] next_pc;
    logic [31:0] cnt_sat;

    rvx_memory #(
        .WORDS (MEMORY_WORDS)
    ) u_memory (
        .clk    (clk),
        .rst_n  (rst_n),
        .busy   (mem_busy),
        .re     (mem_re),
        .r_word (mem_raddr),
        .r_data (mem_rdata),
        .we     (mem_we),
        .w_word (mem_waddr),
        .w_data (mem_wdata)
    );

    rvx_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .ra_en   (rf_ra_en),
        .ra_idx  (rf_ra_idx),
        .ra_data (rf_a),
        .rb_en   (rf_rb_en),
        .rb_idx  (mem_rdata[24:20]),
        .rb_data (rf_b),
        .we      (rf_we),
        .w_idx   (rd_eff),
        .w_data  (val_eff)
    );

    rvx_alu u_alu (
        .a      (rf_a),
        .b      (alu_b),
        .ctl    (alu_ctl),
        .result (alu_res),
        .take   (br_take)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = !in_full_reg && !mem_busy;
    assign take_in   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign opc   = ir_reg[6:0];
    assign rd    = ir_reg[11:7];
    assign f3    = ir_reg[14:12];
    assign f7    = ir_reg[31:25];
    assign imm_i = {{20{ir_reg[31]}}, ir_reg[31:20]};
    assign imm_s = {{20{ir_reg[31]}}, ir_reg[31:25], ir_reg[11:7]};
    assign imm_b = {{19{ir_reg[31]}}, ir_reg[31], ir_reg[7], ir_reg[30:25],
                    ir_reg[11:8], 1'b0};
    assign imm_j = {{11{ir_reg[31]}}, ir_reg[31], ir_reg[19:12], ir_reg[20],
                    ir_reg[30:21], 1'b0};
    assign imm_u = {ir_reg[31:12], 12'd0};

    assign ea    = rf_a + ((opc == OPC_STORE) ? imm_s : imm_i);
    assign alu_b = ((opc == OPC_OP) || (opc == OPC_BRANCH)) ? rf_b : imm_i;
    assign alu_ctl.f3  = f3;
    assign alu_ctl.alt = (opc == OPC_OP) ? (f7 == F7_ALT)
                                         : ((f3 == 3'd5) && ir_reg[30]);

    always_comb
    begin
        case (opc)
            OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_OPIMM, OPC_FENCE, OPC_SYSTEM:
                illegal = 1'b0;
            OPC_BRANCH: illegal = (f3 == 3'd2) || (f3 == 3'd3);
            OPC_LOAD:   illegal = (f3 == 3'd3) || (f3 == 3'd6) || (f3 == 3'd7);
            OPC_STORE:  illegal = f3[2] || (f3 == 3'd3);
            OPC_OP:     illegal = !((f7 == F7_BASE) ||
                                    ((f7 == F7_ALT) && ((f3 == 3'd0) || (f3 == 3'd5))));
            default:    illegal = 1'b1;
        endcase
    end

    assign writes = (opc == OPC_LUI) || (opc == OPC_AUIPC) || (opc == OPC_JAL) ||
                    (opc == OPC_JALR) || (opc == OPC_LOAD) || (opc == OPC_OPIMM) ||
                    (opc == OPC_OP);
    assign is_mem = (opc == OPC_LOAD) || (opc == OPC_STORE);

    assign byte_sh = {ea[1:0], 3'b000};
    assign half_sh = {ea[1], 4'b0000};
    assign bsel    = 8'(mem_rdata >> byte_sh);
    assign hsel    = 16'(mem_rdata >> half_sh);

    always_comb
    begin
        case (f3)
            3'd0:    load_val = {{24{bsel[7]}}, bsel};
            3'd1:    load_val = {{16{hsel[15]}}, hsel};
            3'd4:    load_val = {24'd0, bsel};
            3'd5:    load_val = {16'd0, hsel};
            default: load_val = mem_rdata;
        endcase
    end

    always_comb
    begin
        case (f3)
            3'd0:
            begin
                st_mask = 32'h0000_00FF << byte_sh;
                st_sh   = byte_sh;
            end
            3'd1:
            begin
                st_mask = 32'h0000_FFFF << half_sh;
                st_sh   = half_sh;
            end
            default:
            begin
                st_mask = 32'hFFFF_FFFF;
                st_sh   = 5'd0;
            end
        endcase
    end

    assign merged = (mem_rdata & ~st_mask) | ((rf_b << st_sh) & st_mask);

    always_comb
    begin
        case (opc)
            OPC_LUI:   wr_val = imm_u;
            OPC_AUIPC: wr_val = pc_reg + imm_u;
            OPC_JAL:   wr_val = pc_reg + 32'd4;
            OPC_JALR:  wr_val = pc_reg + 32'd4;
            OPC_LOAD:  wr_val = load_val;
            default:   wr_val = alu_res;
        endcase
    end

    always_comb
    begin
        case (opc)
            OPC_JAL:    next_pc = pc_reg + imm_j;
            OPC_JALR:   next_pc = {ea[31:1], 1'b0};
            OPC_BRANCH: next_pc = br_take ? (pc_reg + imm_b) : (pc_reg + 32'd4);
            default:    next_pc = pc_reg + 32'd4;
        endcase
    end

    assign rd_eff  = writes ? rd : 5'd0;
    assign val_eff = (rd_eff != 5'd0) ? wr_val : 32'd0;
    assign cnt_sat = (cnt_reg == COUNT_MAX) ? cnt_reg : (cnt_reg + 32'd1);

    always_comb
    begin
        st_next   = st_reg;
        consume   = 1'b0;
        emit      = 1'b0;
        commit    = 1'b0;
        res_kind  = KIND_IDLE;
        res_pc    = 32'd0;
        res_word  = 32'd0;
        res_rd    = 5'd0;
        res_val   = 32'd0;
        mem_re    = 1'b0;
        mem_raddr = pc_reg[31:2];
        mem_we    = 1'b0;
        mem_waddr = ea[31:2];
        mem_wdata = merged;
        rf_ra_en  = 1'b0;
        rf_ra_idx = mem_rdata[19:15];
        rf_rb_en  = 1'b0;
        pc_next   = pc_reg;
        halt_next = halt_reg;
        cnt_next  = cnt_reg;
        ir_next   = ir_reg;
        ridx_next = ridx_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_full_reg)
                begin
                    if (buf_op_reg == OPER_WRITE)
                    begin
                        if (out_free)
                        begin
                            consume   = 1'b1;
                            emit      = 1'b1;
                            res_kind  = KIND_WRITTEN;
                            mem_we    = 1'b1;
                            mem_waddr = 30'(buf_addr_reg);
                            mem_wdata = buf_data_reg;
                        end
                    end
                    else if (buf_op_reg == OPER_READ)
                    begin
                        consume   = 1'b1;
                        rf_ra_en  = 1'b1;
                        rf_ra_idx = buf_ridx_reg;
                        ridx_next = buf_ridx_reg;
                        st_next   = ST_RREAD;
                    end
                    else if ((buf_op_reg == OPER_EXEC) && !halt_reg && (cnt_reg < limit_reg))
                    begin
                        consume = 1'b1;
                        mem_re  = 1'b1;
                        st_next = ST_FETCH;
                    end
                    else if (out_free)
                    begin
                        consume  = 1'b1;
                        emit     = 1'b1;
                        res_kind = KIND_IDLE;
                        res_pc   = pc_reg;
                    end
                end
            end
            ST_RREAD:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    res_kind = KIND_REGREAD;
                    res_rd   = ridx_reg;
                    res_val  = rf_a;
                    st_next  = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                ir_next  = mem_rdata;
                rf_ra_en = 1'b1;
                rf_rb_en = 1'b1;
                st_next  = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (illegal)
                begin
                    if (out_free)
                    begin
                        emit      = 1'b1;
                        res_kind  = KIND_ILLEGAL;
                        res_pc    = pc_reg;
                        res_word  = ir_reg;
                        halt_next = 1'b1;
                        st_next   = ST_IDLE;
                    end
                end
                else if (is_mem)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ea[31:2];
                    st_next   = ST_MEM;
                end
                else if (out_free)
                begin
                    commit  = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            ST_MEM:
            begin
                if (out_free)
                begin
                    commit  = 1'b1;
                    mem_we  = (opc == OPC_STORE);
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
        if (commit)
        begin
            emit      = 1'b1;
            res_kind  = (opc == OPC_SYSTEM) ? KIND_HALTED : KIND_RETIRED;
            res_pc    = pc_reg;
            res_word  = ir_reg;
            res_rd    = rd_eff;
            res_val   = val_eff;
            pc_next   = next_pc;
            cnt_next  = cnt_sat;
            halt_next = halt_reg || (opc == OPC_SYSTEM);
        end
    end

    assign rf_we = commit && (rd_eff != 5'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            limit_reg     <= LIMIT_RESET;
            pc_reg        <= 32'd0;
            halt_reg      <= 1'b0;
            cnt_reg       <= 32'd0;
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            pc_reg   <= pc_next;
            halt_reg <= halt_next;
            cnt_reg  <= cnt_next;
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (take_in)
            begin
                in_full_reg <= 1'b1;
            end
            else if (consume)
            begin
                in_full_reg <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ir_reg   <= ir_next;
        ridx_reg <= ridx_next;
        if (take_in)
        begin
            buf_op_reg   <= operation;
            buf_addr_reg <= word_address;
            buf_data_reg <= word_data;
            buf_ridx_reg <= reg_index;
        end
        if (emit)
        begin
            kind_reg   <= res_kind;
            opc_pc_reg <= res_pc;
            word_reg   <= res_word;
            rd_reg     <= res_rd;
            val_reg    <= res_val;
            halted_reg <= halt_next;
            count_reg  <= cnt_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign insn_pc       = opc_pc_reg;
    assign insn_word     = word_reg;
    assign dest_reg      = rd_reg;
    assign dest_value    = val_reg;
    assign now_halted    = halted_reg;
    assign retired_count = count_reg;

endmodule

FILE: rtl/rvx_alu.sv
// ----------------------------------------------------------------------------
// RV32I executor ALU
// Integer operations of the register and immediate forms and branch compare.
// ----------------------------------------------------------------------------
module rvx_alu
    import rvx_pkg::*;
(
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  alu_ctl_t    ctl,
    output logic [31:0] result,
    output logic        take
);

    logic [4:0] sh;

    assign sh = b[4:0];

    always_comb
    begin
        case (ctl.f3)
            3'd0: result = ctl.alt ? (a - b) : (a + b);
            3'd1: result = a << sh;
            3'd2: result = {31'd0, $signed(a) < $signed(b)};
            3'd3: result = {31'd0, a < b};
            3'd4: result = a ^ b;
            3'd5: result = ctl.alt ? 32'($signed(a) >>> sh) : (a >> sh);
            3'd6: result = a | b;
            default: result = a & b;
        endcase
    end

    always_comb
    begin
        case (ctl.f3)
            3'd0: take = (a == b);
            3'd1: take = (a != b);
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = !($signed(a) < $signed(b));
            3'd6: take = a < b;
            3'd7: take = !(a < b);
            default: take = 1'b0;
        endcase
    end

endmodule

FILE: rtl/rvx_regfile.sv
// ----------------------------------------------------------------------------
// RV32I executor register file
// Two registered read ports and one write port, with a valid bit per entry.
// ----------------------------------------------------------------------------
module rvx_regfile
    import rvx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        ra_en,
    input  logic [4:0]  ra_idx,
    output logic [31:0] ra_data,
    input  logic        rb_en,
    input  logic [4:0]  rb_idx,
    output logic [31:0] rb_data,
    input  logic        we,
    input  logic [4:0]  w_idx,
    input  logic [31:0] w_data
);

    logic [31:0] regs [32];
    logic [31:0] valid_reg;
    logic [31:0] ra_raw_reg;
    logic [31:0] rb_raw_reg;
    logic        ra_ok_reg;
    logic        rb_ok_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            regs[w_idx] <= w_data;
        end
        if (ra_en)
        begin
            ra_raw_reg <= regs[ra_idx];
        end
        if (rb_en)
        begin
            rb_raw_reg <= regs[rb_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ra_ok_reg <= 1'b0;
            rb_ok_reg <= 1'b0;
        end
        else
        begin
            if (we && (w_idx != 5'd0))
            begin
                valid_reg[w_idx] <= 1'b1;
            end
            if (ra_en)
            begin
                ra_ok_reg <= valid_reg[ra_idx];
            end
            if (rb_en)
            begin
                rb_ok_reg <= valid_reg[rb_idx];
            end
        end
    end

    assign ra_data = ra_ok_reg ? ra_raw_reg : 32'd0;
    assign rb_data = rb_ok_reg ? rb_raw_reg : 32'd0;

endmodule

FILE: rtl/rvx_memory.sv
// ----------------------------------------------------------------------------
// RV32I executor main memory
// Word memory with one read and one write port and a clearing pass at reset.
// ----------------------------------------------------------------------------
module rvx_memory
    import rvx_pkg::*;
#(
    parameter int unsigned WORDS = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    output logic        busy,
    input  logic        re,
    input  logic [29:0] r_word,
    output logic [31:0] r_data,
    input  logic        we,
    input  logic [29:0] w_word,
    input  logic [31:0] w_data
);

    localparam int unsigned AW = $clog2(WORDS);

    logic [31:0]   mem [WORDS];
    logic [31:0]   r_raw_reg;
    logic          r_ok_reg;
    logic          busy_reg;
    logic [AW-1:0] clr_reg;
    logic          w_go;
    logic [AW-1:0] w_idx;
    logic [31:0]   w_val;

    assign w_go  = busy_reg || (we && (w_word < 30'(WORDS)));
    assign w_idx = busy_reg ? clr_reg : w_word[AW-1:0];
    assign w_val = busy_reg ? 32'd0 : w_data;

    always_ff @(posedge clk)
    begin
        if (w_go)
        begin
            mem[w_idx] <= w_val;
        end
        if (re)
        begin
            r_raw_reg <= mem[r_word[AW-1:0]];
            r_ok_reg  <= (r_word < 30'(WORDS));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            clr_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_reg == AW'(WORDS - 1))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    assign busy   = busy_reg;
    assign r_data = r_ok_reg ? r_raw_reg : 32'd0;

endmodule

FILE: rtl/rvx_checker.sv
// ----------------------------------------------------------------------------
// RV32I executor port checker
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
`include "rv32i_instruction_executor_macros.svh"

module rvx_checker
    import rvx_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  result_kind,
    input logic [31:0] insn_pc,
    input logic [31:0] insn_word,
    input logic [4:0]  dest_reg,
    input logic [31:0] dest_value,
    input logic        now_halted
);

    `RVX_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(dest_value))
    `RVX_ASSERT_SAME(a_halt_kinds, clk, rst_n, out_valid && ((result_kind == KIND_HALTED) || (result_kind == KIND_ILLEGAL)), now_halted)
    `RVX_ASSERT_SAME(a_write_clean, clk, rst_n, out_valid && (result_kind == KIND_WRITTEN), (insn_pc == 32'd0) && (insn_word == 32'd0) && (dest_reg == 5'd0) && (dest_value == 32'd0))
    `RVX_ASSERT_SAME(a_no_x0_value, clk, rst_n, out_valid && (dest_reg == 5'd0) && (result_kind != KIND_REGREAD), dest_value == 32'd0)

endmodule

bind rv32i_instruction_executor rvx_checker u_checker (.*);
